### hw/rtl/sri_pkg.sv
// Shared widths and constants for the moving average and RSI indicator.
package sri_pkg;

    localparam int PRICE_PORT_BITS = 32;
    localparam int WINDOW_BITS     = 8;
    localparam int COUNT_BITS      = 9;
    localparam int SUM_BITS        = 40;
    localparam int FRAC_BITS       = 8;
    localparam int AVG_BITS        = 40;
    localparam int RSI_BITS        = 15;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET   = 8'd14;
    localparam logic [RSI_BITS-1:0]    RSI_NEUTRAL    = 15'd12800;
    localparam logic [RSI_BITS-1:0]    RSI_FULL_SCALE = 15'd25600;

endpackage

### hw/rtl/sri_candle_if.sv
// Input channel carrying one closing price per word.
interface sri_candle_if;

    logic                                valid;
    logic                                ready;
    logic [sri_pkg::PRICE_PORT_BITS-1:0] close_price;

    modport source (output valid, output close_price, input ready);
    modport sink (input valid, input close_price, output ready);

endinterface

### hw/rtl/sri_result_if.sv
// Output channel carrying the average and the strength index of one close.
interface sri_result_if;

    logic                         valid;
    logic                         ready;
    logic [sri_pkg::AVG_BITS-1:0] average_q8;
    logic                         average_valid;
    logic [sri_pkg::RSI_BITS-1:0] strength_index_q8;
    logic                         index_valid;

    modport source (output valid, output average_q8, output average_valid,
                    output strength_index_q8, output index_valid, input ready);
    modport sink (input valid, input average_q8, input average_valid,
                  input strength_index_q8, input index_valid, output ready);

endinterface

### hw/rtl/sri_hist_mem.sv
// Ring of recent closes: one write port and one read port with registered data.
module sri_hist_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/sri_divider.sv
// Restoring divider that retires one quotient bit per cycle.
module sri_divider #(
    parameter int N = 49,
    parameter int M = 8,
    parameter int Q = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [M-1:0] divisor,
    output logic         busy,
    output logic [Q-1:0] quotient
);

    localparam int CW = $clog2(Q + 1);

    logic [M-1:0]  rem_reg;
    logic [Q-1:0]  low_reg;
    logic [Q-1:0]  quot_reg;
    logic [CW-1:0] count_reg;
    logic          busy_reg;
    logic [M:0]    cand;
    logic          take;

    // The upper dividend bits are known to be below the divisor, so only
    // Q quotient bits remain to be found.
    always_comb
    begin
        cand = {rem_reg, low_reg[Q-1]};
        take = cand >= {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            low_reg   <= '0;
            quot_reg  <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else if (start)
        begin
            rem_reg   <= M'(dividend[N-1:Q]);
            low_reg   <= dividend[Q-1:0];
            quot_reg  <= '0;
            count_reg <= CW'(Q);
            busy_reg  <= 1'b1;
        end
        else if (busy_reg)
        begin
            rem_reg   <= take ? M'(cand - {1'b0, divisor}) : cand[M-1:0];
            low_reg   <= {low_reg[Q-2:0], 1'b0};
            quot_reg  <= {quot_reg[Q-2:0], take};
            count_reg <= count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

### hw/rtl/sma_rsi_indicator_unit.sv
// Simple moving average and Cutler RSI over a ring of recent closes.
//
// Closes arrive as words on the candle channel; each one yields exactly one
// word on the result channel with the Q.8 average, the Q.8 strength index
// and their valid flags. The window length is written through cfg_wr_en and
// cfg_wr_data while the unit is idle; a write also clears the history.
//
// One close is in work at a time. After a close is accepted, three reads of
// the history memory (one port, registered read data) and the write-back
// take the states S_READ_PREV through S_UPDATE; S_PREP and S_START prepare
// the operands, and the two quotients come from bit-serial dividers running
// side by side; the 48-bit average quotient sets the pace. The result word
// appears once both dividers are done and the output register is free, and
// the unit can take the next close in that same cycle.
//
// The result sits in an output register. If the receiver stalls, the unit
// finishes the next close and holds it until that register is free.
// Reset sets the window to 14 and clears the counts and sums; the history
// memory is not cleared, the counts keep unwritten entries from being used.
module sma_rsi_indicator_unit #(
    parameter int HISTORY_DEPTH = 256,
    parameter int PRICE_BITS    = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sri_pkg::WINDOW_BITS-1:0] cfg_wr_data,
    sri_candle_if.sink                      candle,
    sri_result_if.source                    result
);

    localparam int PW    = (PRICE_BITS < sri_pkg::PRICE_PORT_BITS) ?
                           PRICE_BITS : sri_pkg::PRICE_PORT_BITS;
    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int WMAX  = (HISTORY_DEPTH - 1 < 255) ? HISTORY_DEPTH - 1 : 255;
    localparam int IW    = ((AW > sri_pkg::COUNT_BITS) ? AW : sri_pkg::COUNT_BITS) + 2;
    localparam int SB    = sri_pkg::SUM_BITS;
    localparam int CB    = sri_pkg::COUNT_BITS;
    localparam int AVG_N = SB + sri_pkg::FRAC_BITS + 1;
    localparam int AVG_Q = SB + sri_pkg::FRAC_BITS;
    localparam int RSI_N = SB + sri_pkg::RSI_BITS;
    localparam int RSI_M = SB + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_PREV,
        S_READ_DROP,
        S_READ_OLD,
        S_UPDATE,
        S_PREP,
        S_START,
        S_DIVIDE
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [sri_pkg::WINDOW_BITS-1:0] window_reg;
    logic [sri_pkg::WINDOW_BITS-1:0] win_eff;
    logic [AW-1:0]                 slot_reg;
    logic [CB-1:0]                 seen_reg;
    logic [SB-1:0]                 price_sum_reg;
    logic [SB-1:0]                 gain_sum_reg;
    logic [SB-1:0]                 loss_sum_reg;
    logic [PW-1:0]                 price_reg;
    logic [PW-1:0]                 drop_reg;
    logic [RSI_N-1:0]              num_reg;
    logic [RSI_M-1:0]              total_reg;
    logic                          avg_ok_reg;
    logic                          rsi_ok_reg;

    logic                          out_valid_reg;
    logic [sri_pkg::AVG_BITS-1:0]  out_avg_reg;
    logic                          out_avg_ok_reg;
    logic [sri_pkg::RSI_BITS-1:0]  out_rsi_reg;
    logic                          out_rsi_ok_reg;

    logic [CB-1:0]                 win_k;
    logic [CB-1:0]                 win_k1;
    logic                          have_prev;
    logic                          have_drop;
    logic                          have_old;
    logic [AW-1:0]                 rd_addr;
    logic [PW-1:0]                 rd_data;
    logic [PW-1:0]                 rise_new;
    logic [PW-1:0]                 fall_new;
    logic [PW-1:0]                 rise_old;
    logic [PW-1:0]                 fall_old;
    logic                          mem_wr_en;
    logic                          div_start;
    logic                          avg_busy;
    logic                          rsi_busy;
    logic [AVG_Q-1:0]              avg_quot;
    logic [sri_pkg::RSI_BITS-1:0]  rsi_quot;
    logic                          out_free;
    logic                          accept;

    function automatic logic [AW-1:0] back_slot(input logic [AW-1:0] ws,
                                                 input logic [CB-1:0] k);
        logic [IW-1:0] d;
        d = IW'(ws) - IW'(k);
        if (d[IW-1])
        begin
            d = d + IW'(HISTORY_DEPTH);
        end
        return d[AW-1:0];
    endfunction

    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = sri_pkg::WINDOW_BITS'(1);
        end
        else if (32'(window_reg) > WMAX)
        begin
            win_eff = sri_pkg::WINDOW_BITS'(WMAX);
        end
        else
        begin
            win_eff = window_reg;
        end
        win_k     = CB'(win_eff);
        win_k1    = CB'(win_eff) + CB'(1);
        have_prev = seen_reg != '0;
        have_drop = seen_reg >= win_k;
        have_old  = seen_reg >= win_k1;
        rise_new  = price_reg - rd_data;
        fall_new  = rd_data - price_reg;
        rise_old  = drop_reg - rd_data;
        fall_old  = rd_data - drop_reg;
    end

    always_comb
    begin
        unique case (state_reg)
            S_READ_DROP: rd_addr = back_slot(slot_reg, win_k);
            S_READ_OLD:  rd_addr = back_slot(slot_reg, win_k1);
            default:     rd_addr = back_slot(slot_reg, CB'(1));
        endcase
    end

    assign mem_wr_en = state_reg == S_UPDATE;
    assign div_start = state_reg == S_START;
    assign out_free  = !out_valid_reg || result.ready;
    assign accept    = candle.valid && candle.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (candle.valid) state_next = S_READ_PREV;
            S_READ_PREV: state_next = S_READ_DROP;
            S_READ_DROP: state_next = S_READ_OLD;
            S_READ_OLD:  state_next = S_UPDATE;
            S_UPDATE:    state_next = S_PREP;
            S_PREP:      state_next = S_START;
            S_START:     state_next = S_DIVIDE;
            S_DIVIDE:    if (!avg_busy && !rsi_busy && out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_reg     <= sri_pkg::WINDOW_RESET;
            slot_reg       <= '0;
            seen_reg       <= '0;
            price_sum_reg  <= '0;
            gain_sum_reg   <= '0;
            loss_sum_reg   <= '0;
            price_reg      <= '0;
            drop_reg       <= '0;
            num_reg        <= '0;
            total_reg      <= '0;
            avg_ok_reg     <= 1'b0;
            rsi_ok_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_avg_reg    <= '0;
            out_avg_ok_reg <= 1'b0;
            out_rsi_reg    <= '0;
            out_rsi_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DIVIDE && !avg_busy && !rsi_busy && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                window_reg    <= cfg_wr_data;
                slot_reg      <= '0;
                seen_reg      <= '0;
                price_sum_reg <= '0;
                gain_sum_reg  <= '0;
                loss_sum_reg  <= '0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        price_reg <= candle.close_price[PW-1:0];
                    end
                end
                S_READ_PREV:
                begin
                end
                S_READ_DROP:
                begin
                    // Read data is the previous close.
                    if (have_prev && price_reg > rd_data)
                    begin
                        gain_sum_reg <= gain_sum_reg + SB'(rise_new);
                    end
                    else if (have_prev && price_reg < rd_data)
                    begin
                        loss_sum_reg <= loss_sum_reg + SB'(fall_new);
                    end
                end
                S_READ_OLD:
                begin
                    // Read data is the close leaving the average window.
                    drop_reg      <= rd_data;
                    price_sum_reg <= price_sum_reg + SB'(price_reg)
                                     - (have_drop ? SB'(rd_data) : SB'(0));
                end
                S_UPDATE:
                begin
                    // Read data is the close before it; their change leaves the window.
                    if (have_old && drop_reg > rd_data)
                    begin
                        gain_sum_reg <= gain_sum_reg - SB'(rise_old);
                    end
                    else if (have_old && drop_reg < rd_data)
                    begin
                        loss_sum_reg <= loss_sum_reg - SB'(fall_old);
                    end
                    slot_reg <= (slot_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + AW'(1);
                    if (seen_reg < win_k1)
                    begin
                        seen_reg <= seen_reg + CB'(1);
                    end
                end
                S_PREP:
                begin
                    avg_ok_reg <= seen_reg >= win_k;
                    rsi_ok_reg <= seen_reg >= win_k1;
                    // 25600 * G built from shifts: 25600 = 2^14 + 2^13 + 2^10.
                    num_reg    <= (RSI_N'(gain_sum_reg) << 14) + (RSI_N'(gain_sum_reg) << 13)
                                  + (RSI_N'(gain_sum_reg) << 10);
                    total_reg  <= RSI_M'(gain_sum_reg) + RSI_M'(loss_sum_reg);
                end
                S_START:
                begin
                end
                S_DIVIDE:
                begin
                    if (!avg_busy && !rsi_busy && out_free)
                    begin
                        out_avg_ok_reg <= avg_ok_reg;
                        out_rsi_ok_reg <= rsi_ok_reg;
                        out_avg_reg    <= avg_ok_reg ? avg_quot[sri_pkg::AVG_BITS-1:0] : '0;
                        if (!rsi_ok_reg)
                        begin
                            out_rsi_reg <= '0;
                        end
                        else if (total_reg == '0)
                        begin
                            out_rsi_reg <= sri_pkg::RSI_NEUTRAL;
                        end
                        else
                        begin
                            out_rsi_reg <= rsi_quot;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    sri_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (PW)
    ) u_hist (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (slot_reg),
        .wr_data (price_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sri_divider #(
        .N (AVG_N),
        .M (sri_pkg::WINDOW_BITS),
        .Q (AVG_Q)
    ) u_avg_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({1'b0, price_sum_reg, {sri_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (win_eff),
        .busy     (avg_busy),
        .quotient (avg_quot)
    );

    sri_divider #(
        .N (RSI_N),
        .M (RSI_M),
        .Q (sri_pkg::RSI_BITS)
    ) u_rsi_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (total_reg),
        .busy     (rsi_busy),
        .quotient (rsi_quot)
    );

    assign candle.ready             = state_reg == S_IDLE;
    assign result.valid             = out_valid_reg;
    assign result.average_q8        = out_avg_reg;
    assign result.average_valid     = out_avg_ok_reg;
    assign result.strength_index_q8 = out_rsi_reg;
    assign result.index_valid       = out_rsi_ok_reg;

endmodule

### hw/rtl/sri_checker.sv
// Port-level checks for the indicator unit, bound to its top level.
module sri_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         candle_valid,
    input logic                         candle_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [sri_pkg::AVG_BITS-1:0] average_q8,
    input logic                         average_valid,
    input logic [sri_pkg::RSI_BITS-1:0] strength_index_q8,
    input logic                         index_valid
);

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its average and strength index.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(average_q8) && $stable(strength_index_q8))
        else $error("result payload changed while stalled");

    // Only one close is in work, so the cycle after a word is taken is never ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        candle_valid && candle_ready |=> !candle_ready)
        else $error("second close taken while one is in work");

    // The strength index never exceeds 100.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> strength_index_q8 <= sri_pkg::RSI_FULL_SCALE)
        else $error("strength index out of range");

    // The index needs one more close than the average.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && index_valid |-> average_valid)
        else $error("index valid without average valid");

endmodule

bind sma_rsi_indicator_unit sri_checker u_sri_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .candle_valid      (candle.valid),
    .candle_ready      (candle.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .average_q8        (result.average_q8),
    .average_valid     (result.average_valid),
    .strength_index_q8 (result.strength_index_q8),
    .index_valid       (result.index_valid)
);

### tb/sv/sma_rsi_indicator_unit_tb.sv
// Self-checking testbench for the moving average and RSI indicator unit.
module sma_rsi_indicator_unit_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_CLOSES = 500;
    localparam int RING_DEPTH    = 256;

    typedef struct packed {
        logic [sri_pkg::AVG_BITS-1:0] average_q8;
        logic                         average_valid;
        logic [sri_pkg::RSI_BITS-1:0] strength_index_q8;
        logic                         index_valid;
    } quote_t;

    typedef enum logic [1:0] {
        ROW_WINDOW,
        ROW_CLOSE,
        ROW_CLOSE_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t                           kind;
        logic [sri_pkg::PRICE_PORT_BITS-1:0] value;
        quote_t                              known;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 21;

    // Rows with a typed quote check the cases whose outcome is obvious; the rest
    // go through the indicator model below.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_CLOSE_KNOWN, 32'h0000_0000, '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE_KNOWN, 32'hFFFF_FFFF, '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE,       32'd12345,     '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_WINDOW,      32'd1,         '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE_KNOWN, 32'h0000_0000, '{40'd0, 1'b1, 15'd0, 1'b0}},
        '{ROW_CLOSE_KNOWN, 32'hFFFF_FFFF,
          '{40'hFF_FFFF_FF00, 1'b1, sri_pkg::RSI_FULL_SCALE, 1'b1}},
        '{ROW_CLOSE_KNOWN, 32'hFFFF_FFFF,
          '{40'hFF_FFFF_FF00, 1'b1, sri_pkg::RSI_NEUTRAL, 1'b1}},
        '{ROW_CLOSE_KNOWN, 32'h0000_0000, '{40'd0, 1'b1, 15'd0, 1'b1}},
        '{ROW_WINDOW,      32'd0,         '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE_KNOWN, 32'd5,         '{40'd1280, 1'b1, 15'd0, 1'b0}},
        '{ROW_CLOSE_KNOWN, 32'd5,         '{40'd1280, 1'b1, sri_pkg::RSI_NEUTRAL, 1'b1}},
        '{ROW_WINDOW,      32'd3,         '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE,       32'd1,         '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE,       32'd1,         '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE,       32'd2,         '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE,       32'd0,         '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE,       32'd7,         '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_WINDOW,      32'd255,       '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE,       32'hFFFF_FFFF, '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE,       32'h0000_0000, '{40'd0, 1'b0, 15'd0, 1'b0}},
        '{ROW_CLOSE,       32'h8000_0000, '{40'd0, 1'b0, 15'd0, 1'b0}}
    };

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [sri_pkg::WINDOW_BITS-1:0] cfg_wr_data;

    sri_candle_if candle_bus ();
    sri_result_if result_bus ();

    sma_rsi_indicator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .candle      (candle_bus),
        .result      (result_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Indicator model state.
    logic [sri_pkg::PRICE_PORT_BITS-1:0] close_ring [RING_DEPTH];
    logic [7:0]                          ring_head;
    logic [sri_pkg::COUNT_BITS-1:0]      closes_seen;
    logic [63:0]                         close_total;
    logic [63:0]                         rise_total;
    logic [63:0]                         fall_total;
    logic [sri_pkg::WINDOW_BITS-1:0]     window_reg;

    quote_t                              pending_quotes [$];
    int                                  mismatches = 0;
    int                                  cycle_count = 0;
    int                                  burst_left = 0;
    logic [sri_pkg::PRICE_PORT_BITS-1:0] last_price = '0;
    logic [15:0]                         stall_pattern = 16'hFFFF;
    int                                  stall_age = 0;

    // An 8-bit register can never exceed the ring depth minus one, so only
    // the zero window needs adjusting.
    function automatic int unsigned span();
        return (window_reg == 0) ? 1 : int'(window_reg);
    endfunction

    function automatic int unsigned ring_back(int unsigned k);
        return (int'(ring_head) + RING_DEPTH - (k % RING_DEPTH)) % RING_DEPTH;
    endfunction

    function automatic void clear_indicator();
        ring_head   = '0;
        closes_seen = '0;
        close_total = '0;
        rise_total  = '0;
        fall_total  = '0;
    endfunction

    function automatic quote_t advance_indicator(logic [sri_pkg::PRICE_PORT_BITS-1:0] price);
        int unsigned                         w;
        logic [sri_pkg::PRICE_PORT_BITS-1:0] older;
        logic [sri_pkg::PRICE_PORT_BITS-1:0] newer;
        logic [63:0]                         movement;
        logic [63:0]                         avg;
        logic [63:0]                         rsi;
        quote_t                              q;
        w   = span();
        avg = '0;
        rsi = '0;
        if (closes_seen >= 1)
        begin
            newer = close_ring[ring_back(1)];
            if (price > newer)
                rise_total += price - newer;
            else if (price < newer)
                fall_total += newer - price;
        end
        // The change that falls out of the window is taken back out of its sum.
        if (closes_seen >= w + 1)
        begin
            older = close_ring[ring_back(w + 1)];
            newer = close_ring[ring_back(w)];
            if (newer > older)
                rise_total -= newer - older;
            else if (newer < older)
                fall_total -= older - newer;
        end
        close_total += price;
        if (closes_seen >= w)
            close_total -= close_ring[ring_back(w)];
        close_ring[ring_head] = price;
        ring_head = ring_head + 8'd1;
        if (closes_seen < w + 1)
            closes_seen = closes_seen + 1'b1;

        q.average_valid = (closes_seen >= w);
        q.index_valid   = (closes_seen >= w + 1);
        if (q.average_valid)
            avg = ((close_total / w) << 8) + (((close_total % w) << 8) / w);
        if (q.index_valid)
        begin
            movement = rise_total + fall_total;
            rsi = (movement == 0) ? 64'(sri_pkg::RSI_NEUTRAL)
                                  : (rise_total * 25600) / movement;
        end
        q.average_q8        = avg[sri_pkg::AVG_BITS-1:0];
        q.strength_index_q8 = rsi[sri_pkg::RSI_BITS-1:0];
        return q;
    endfunction

    // Mostly a random walk, with jumps, flat stretches and rail values mixed in.
    function automatic logic [sri_pkg::PRICE_PORT_BITS-1:0] next_price();
        int mode;
        mode = $urandom_range(0, 19);
        case (mode)
            0:       last_price = '0;
            1:       last_price = '1;
            2, 3:    last_price = $urandom;
            4, 5, 6: last_price = last_price;
            default: last_price = last_price + $urandom_range(0, 2000) - 1000;
        endcase
        return last_price;
    endfunction

    task automatic send_close(input logic [sri_pkg::PRICE_PORT_BITS-1:0] price,
                              input bit typed, input quote_t typed_quote);
        int     gap;
        quote_t q;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap != 0)
            begin
                candle_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        candle_bus.valid       <= 1'b1;
        candle_bus.close_price <= price;
        do
            @(posedge clk);
        while (!candle_bus.ready);
        q = advance_indicator(price);
        pending_quotes.push_back(typed ? typed_quote : q);
    endtask

    // The window may only change with no close in flight.
    task automatic set_window(input logic [sri_pkg::WINDOW_BITS-1:0] length);
        candle_bus.valid <= 1'b0;
        while (pending_quotes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= length;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        window_reg = length;
        clear_indicator();
    endtask

    // The receiver stalls on a rotating pattern that is redrawn now and then.
    always @(posedge clk)
    begin
        if (stall_age == 150)
        begin
            stall_age <= 0;
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                          : (16'($urandom) | 16'h0001);
        end
        else
        begin
            stall_age <= stall_age + 1;
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
        end
        result_bus.ready <= stall_pattern[15];
    end

    always @(posedge clk)
    begin
        quote_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_quotes.size() == 0)
            begin
                $error("result word with nothing expected: average_q8 %0h",
                       result_bus.average_q8);
                mismatches++;
            end
            else
            begin
                want = pending_quotes.pop_front();
                if (result_bus.average_q8 !== want.average_q8)
                begin
                    $error("average_q8: expected %0h, got %0h",
                           want.average_q8, result_bus.average_q8);
                    mismatches++;
                end
                if (result_bus.average_valid !== want.average_valid)
                begin
                    $error("average_valid: expected %0b, got %0b",
                           want.average_valid, result_bus.average_valid);
                    mismatches++;
                end
                if (result_bus.strength_index_q8 !== want.strength_index_q8)
                begin
                    $error("strength_index_q8: expected %0d, got %0d",
                           want.strength_index_q8, result_bus.strength_index_q8);
                    mismatches++;
                end
                if (result_bus.index_valid !== want.index_valid)
                begin
                    $error("index_valid: expected %0b, got %0b",
                           want.index_valid, result_bus.index_valid);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sma_rsi_indicator_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        int random_sent;
        int phase_closes;
        logic [sri_pkg::WINDOW_BITS-1:0] length;

        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        candle_bus.valid       = 1'b0;
        candle_bus.close_price = '0;
        window_reg             = sri_pkg::WINDOW_RESET;
        clear_indicator();
        random_sent            = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_WINDOW:      set_window(directed_rows[i].value[sri_pkg::WINDOW_BITS-1:0]);
                ROW_CLOSE:       send_close(directed_rows[i].value, 1'b0, '0);
                ROW_CLOSE_KNOWN: send_close(directed_rows[i].value, 1'b1,
                                            directed_rows[i].known);
                default:         ;
            endcase
        end

        // A window one below the widest first, long enough to slide past its end.
        set_window(8'd254);
        repeat (262)
        begin
            send_close(next_price(), 1'b0, '0);
            random_sent++;
        end

        while (random_sent < RANDOM_CLOSES)
        begin
            length = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 24));
            set_window(length);
            phase_closes = $urandom_range(20, 50);
            repeat (phase_closes)
            begin
                send_close(next_price(), 1'b0, '0);
                random_sent++;
            end
        end

        candle_bus.valid <= 1'b0;
        while (pending_quotes.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("sma_rsi_indicator_unit: match");
        else
            $display("sma_rsi_indicator_unit: mismatch");
        $finish;
    end

endmodule
